// ----- hdl/rmsvad_pkg.sv -----
// shared widths, constants and types of the rms energy voice activity detector
package rmsvad_pkg;

  // payload and state widths
  localparam int SAMPLE_W = 16;
  localparam int MAG_W    = 17;
  localparam int SQ_W     = 31;
  localparam int SUM_W    = 43;
  localparam int COUNT_W  = 13;
  localparam int RMS_W    = 16;
  localparam int LEVEL_W  = 7;
  localparam int RUN_W    = 8;

  // frame closes on its own at this many samples
  localparam int MAX_FRAME_SAMPLES = 4096;

  // shared subtract unit and its iteration counts
  localparam int SUB_W      = 19;
  localparam int REM_W      = 17;
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = RMS_W;
  localparam int STEP_W     = 6;

  // smoothing and meter constants
  localparam int SMOOTH_W   = 19;
  localparam int SMOOTH_MUL = 7;
  localparam int SMOOTH_SH  = 3;
  localparam int PCT_W      = 23;
  localparam int PCT_MUL    = 100;
  localparam int PCT_SH     = 15;
  localparam int LEVEL_MAX  = 100;
  localparam int RUN_MAX    = 255;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_RMS_THRESHOLD       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPEECH_FRAME_LIMIT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SILENCE_FRAME_LIMIT = 2'd2;
  localparam logic [15:0] RESET_RMS_THRESHOLD       = 16'd900;
  localparam logic [7:0]  RESET_SPEECH_FRAME_LIMIT  = 8'd2;
  localparam logic [7:0]  RESET_SILENCE_FRAME_LIMIT = 8'd12;

  // input opcodes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // configuration register set
  typedef struct packed {
    logic [15:0] rms_threshold;
    logic [7:0]  speech_frame_limit;
    logic [7:0]  silence_frame_limit;
  } cfg_t;

  // from the rms engine to the tracker
  typedef struct packed {
    logic             valid;
    logic             clear;
    logic [RMS_W-1:0] rms;
  } frame_t;

endpackage

// ----- hdl/rmsvad_ifs.sv -----
// valid/ready channels for samples in and frame results out

interface rmsvad_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 opcode;
  logic signed [rmsvad_pkg::SAMPLE_W-1:0] sample;
  logic                                 frame_last;

  modport source (output valid, opcode, sample, frame_last, input ready);
  modport sink (input valid, opcode, sample, frame_last, output ready);
endinterface

interface rmsvad_out_if;
  logic                              valid;
  logic                              ready;
  logic [rmsvad_pkg::RMS_W-1:0]      frame_rms;
  logic [rmsvad_pkg::LEVEL_W-1:0]    level_percent;
  logic                              speech_active;
  logic                              wake_latched;

  modport source (output valid, frame_rms, level_percent, speech_active, wake_latched,
                  input ready);
  modport sink (input valid, frame_rms, level_percent, speech_active, wake_latched,
                output ready);
endinterface

// ----- hdl/rmsvad_sub.sv -----
// shared trial subtractor used by the divide and square root steps
module rmsvad_sub (
  input  logic [rmsvad_pkg::SUB_W-1:0] a,
  input  logic [rmsvad_pkg::SUB_W-1:0] b,
  output logic [rmsvad_pkg::SUB_W-1:0] diff,
  output logic                         borrow
);

  // borrow set means a < b
  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

// ----- hdl/rmsvad_engine.sv -----
// energy accumulator and rms sequencer: square, add, long divide, digit square root
module rmsvad_engine (
  input  logic                clk,
  input  logic                rst,
  rmsvad_in_if.sink           din,
  output rmsvad_pkg::frame_t  frame,
  input  logic                frame_ready
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]                          state;
  logic [rmsvad_pkg::MAG_W-1:0]        mag;
  logic                                last;
  logic [rmsvad_pkg::SQ_W-1:0]         square;
  logic [rmsvad_pkg::SUM_W-1:0]        sum;
  logic [rmsvad_pkg::COUNT_W-1:0]      count;
  logic [rmsvad_pkg::REM_W-1:0]        rem;
  logic [rmsvad_pkg::RMS_W-1:0]        root;
  logic [rmsvad_pkg::STEP_W-1:0]       step;

  logic                                accept;
  logic [rmsvad_pkg::MAG_W-1:0]        mag_next;
  logic [2*rmsvad_pkg::MAG_W-1:0]      square_full;
  logic [rmsvad_pkg::COUNT_W-1:0]      count_next;
  logic [rmsvad_pkg::SUB_W-1:0]        sub_a;
  logic [rmsvad_pkg::SUB_W-1:0]        sub_b;
  logic [rmsvad_pkg::SUB_W-1:0]        sub_diff;
  logic                                sub_borrow;

  assign din.ready = (state == S_IDLE);
  assign accept    = din.valid && din.ready;

  // magnitude of the sample, 32768 for the most negative code
  assign mag_next = din.sample[rmsvad_pkg::SAMPLE_W-1]
                  ? (rmsvad_pkg::MAG_W'(1 << rmsvad_pkg::SAMPLE_W)
                     - {1'b0, din.sample})
                  : {1'b0, din.sample};

  assign square_full = mag * mag;
  assign count_next  = count + rmsvad_pkg::COUNT_W'(1);

  // operand select for the shared subtractor
  always_comb begin
    if (state == S_DIV) begin
      sub_a = rmsvad_pkg::SUB_W'({rem[rmsvad_pkg::COUNT_W-1:0], sum[rmsvad_pkg::SUM_W-1]});
      sub_b = rmsvad_pkg::SUB_W'(count);
    end else begin
      sub_a = {rem, sum[31:30]};
      sub_b = rmsvad_pkg::SUB_W'({root, 2'b01});
    end
  end

  rmsvad_sub u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  // handshake toward the tracker
  always_comb begin
    frame.valid = (state == S_DONE);
    frame.clear = accept && (din.opcode == rmsvad_pkg::OP_CLEAR);
    frame.rms   = root;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sum   <= '0;
      count <= '0;
      rem   <= '0;
      root  <= '0;
      step  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && din.opcode == rmsvad_pkg::OP_SAMPLE) begin
            mag   <= mag_next;
            last  <= din.frame_last;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          square <= square_full[rmsvad_pkg::SQ_W-1:0];
          state  <= S_ACC;
        end
        S_ACC: begin
          sum   <= sum + rmsvad_pkg::SUM_W'(square);
          count <= count_next;
          step  <= '0;
          rem   <= '0;
          if (last || count_next == rmsvad_pkg::COUNT_W'(rmsvad_pkg::MAX_FRAME_SAMPLES)) begin
            state <= S_DIV;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          // one quotient bit per cycle, shifted in behind the dividend
          sum <= {sum[rmsvad_pkg::SUM_W-2:0], ~sub_borrow};
          if (step == rmsvad_pkg::STEP_W'(rmsvad_pkg::DIV_STEPS - 1)) begin
            // the square root starts from a clean remainder
            rem   <= '0;
            step  <= '0;
            state <= S_SQRT;
          end else begin
            if (!sub_borrow) begin
              rem <= rmsvad_pkg::REM_W'(sub_diff[rmsvad_pkg::COUNT_W-1:0]);
            end else begin
              rem <= rmsvad_pkg::REM_W'(sub_a[rmsvad_pkg::COUNT_W-1:0]);
            end
            step <= step + rmsvad_pkg::STEP_W'(1);
          end
        end
        S_SQRT: begin
          // one root bit per cycle from two quotient bits
          if (!sub_borrow) begin
            rem  <= sub_diff[rmsvad_pkg::REM_W-1:0];
            root <= {root[rmsvad_pkg::RMS_W-2:0], 1'b1};
          end else begin
            rem  <= sub_a[rmsvad_pkg::REM_W-1:0];
            root <= {root[rmsvad_pkg::RMS_W-2:0], 1'b0};
          end
          sum <= {sum[rmsvad_pkg::SUM_W-3:0], 2'b00};
          if (step == rmsvad_pkg::STEP_W'(rmsvad_pkg::SQRT_STEPS - 1)) begin
            step  <= '0;
            state <= S_DONE;
          end else begin
            step <= step + rmsvad_pkg::STEP_W'(1);
          end
        end
        S_DONE: begin
          if (frame_ready) begin
            sum   <= '0;
            count <= '0;
            rem   <= '0;
            root  <= '0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/rmsvad_track.sv -----
// smoothed level meter, silence/speech machine, wake latch and result register
module rmsvad_track (
  input  logic                clk,
  input  logic                rst,
  input  rmsvad_pkg::cfg_t    cfg,
  input  rmsvad_pkg::frame_t  frame,
  output logic                frame_ready,
  rmsvad_out_if.source        dout
);

  logic [rmsvad_pkg::RMS_W-1:0]    smoothed;
  logic                            voice;
  logic                            wake;
  logic [rmsvad_pkg::RUN_W-1:0]    loud_run;
  logic [rmsvad_pkg::RUN_W-1:0]    quiet_run;
  logic                            pend;
  logic                            out_valid;

  logic                            take;
  logic                            loud;
  logic [rmsvad_pkg::RUN_W-1:0]    loud_inc;
  logic [rmsvad_pkg::RUN_W-1:0]    quiet_inc;
  logic [rmsvad_pkg::SMOOTH_W-1:0] smooth_sum;
  logic [rmsvad_pkg::PCT_W-1:0]    pct_prod;
  logic [rmsvad_pkg::RUN_W-1:0]    pct;
  logic                            voice_next;
  logic                            wake_next;

  assign frame_ready = !pend && (!out_valid || dout.ready);
  assign take        = frame.valid && frame_ready;
  assign dout.valid  = out_valid;

  // loudness decision and saturating run counts
  assign loud      = (frame.rms >= cfg.rms_threshold);
  assign loud_inc  = (loud_run == rmsvad_pkg::RUN_W'(rmsvad_pkg::RUN_MAX))
                   ? loud_run : loud_run + rmsvad_pkg::RUN_W'(1);
  assign quiet_inc = (quiet_run == rmsvad_pkg::RUN_W'(rmsvad_pkg::RUN_MAX))
                   ? quiet_run : quiet_run + rmsvad_pkg::RUN_W'(1);

  // smoothing: (level*7 + rms) / 8
  assign smooth_sum = rmsvad_pkg::SMOOTH_W'(smoothed) * rmsvad_pkg::SMOOTH_W'(rmsvad_pkg::SMOOTH_MUL)
                    + rmsvad_pkg::SMOOTH_W'(frame.rms);

  // percent meter from the registered smoothed level
  assign pct_prod = rmsvad_pkg::PCT_W'(smoothed) * rmsvad_pkg::PCT_W'(rmsvad_pkg::PCT_MUL);
  assign pct      = pct_prod[rmsvad_pkg::PCT_W-1:rmsvad_pkg::PCT_SH];

  // voice state machine
  always_comb begin
    voice_next = voice;
    wake_next  = wake;
    if (loud) begin
      if (!voice && loud_inc >= cfg.speech_frame_limit) begin
        voice_next = 1'b1;
        wake_next  = 1'b1;
      end
    end else begin
      if (voice && quiet_inc >= cfg.silence_frame_limit) begin
        voice_next = 1'b0;
      end
    end
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed  <= '0;
      voice     <= 1'b0;
      wake      <= 1'b0;
      loud_run  <= '0;
      quiet_run <= '0;
    end else if (take) begin
      smoothed <= smooth_sum[rmsvad_pkg::SMOOTH_W-1:rmsvad_pkg::SMOOTH_SH];
      voice    <= voice_next;
      wake     <= wake_next;
      if (loud) begin
        loud_run  <= loud_inc;
        quiet_run <= '0;
      end else begin
        quiet_run <= quiet_inc;
        loud_run  <= '0;
      end
    end else if (frame.clear) begin
      wake <= 1'b0;
    end
  end

  // result register: fields on transfer from the engine, level in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else if (take) begin
      pend      <= 1'b1;
      out_valid <= 1'b0;
    end else if (pend) begin
      pend      <= 1'b0;
      out_valid <= 1'b1;
    end else if (out_valid && dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dout.frame_rms     <= frame.rms;
      dout.speech_active <= voice_next;
      dout.wake_latched  <= wake_next;
    end
    if (pend) begin
      dout.level_percent <= (pct > rmsvad_pkg::RUN_W'(rmsvad_pkg::LEVEL_MAX))
                          ? rmsvad_pkg::LEVEL_W'(rmsvad_pkg::LEVEL_MAX)
                          : pct[rmsvad_pkg::LEVEL_W-1:0];
    end
  end

endmodule

// ----- hdl/rms_energy_voice_activity_detector_unit.sv -----
// top level of the rms energy voice activity detector
//
// din carries one item per transfer: opcode 0 adds a signed 16-bit sample
// to the running frame energy, opcode 1 clears the wake latch and makes no
// result. frame_last, or the 4096th sample of a frame, closes the frame.
// dout carries one result per closed frame: frame rms, smoothed level in
// percent, speech state and wake latch.
// A sample that leaves the frame open holds din off while it is squared
// and then accumulated; no new sample is taken before that is done. A closing
// sample adds a restoring divide and a digit square root on one shared
// subtractor, then the transfer into the tracker and the level meter update;
// din is ready again before dout valid rises.
// A clear opcode leaves din ready.
// A finished result waits in the dout register; the engine still takes
// samples meanwhile and only holds din off if a second frame closes before
// the first result has been taken.
// Reset (rst, synchronous) empties the frame, zeroes the smoothed level and
// run counts, returns to silence, clears the wake latch and loads the
// registers with threshold 900, speech limit 2 and silence limit 12.
// Configuration writes (cfg_we, cfg_index, cfg_data) go through registers before they take effect.
module rms_energy_voice_activity_detector_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  rmsvad_in_if.sink                              din,
  rmsvad_out_if.source                           dout,
  input  logic                                   cfg_we,
  input  logic [rmsvad_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rmsvad_pkg::CFG_DATA_W-1:0]      cfg_data
);

  rmsvad_pkg::cfg_t   cfg;
  rmsvad_pkg::frame_t frame;
  logic               frame_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rms_threshold       <= rmsvad_pkg::RESET_RMS_THRESHOLD;
      cfg.speech_frame_limit  <= rmsvad_pkg::RESET_SPEECH_FRAME_LIMIT;
      cfg.silence_frame_limit <= rmsvad_pkg::RESET_SILENCE_FRAME_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        rmsvad_pkg::CFG_RMS_THRESHOLD: begin
          cfg.rms_threshold <= cfg_data;
        end
        rmsvad_pkg::CFG_SPEECH_FRAME_LIMIT: begin
          cfg.speech_frame_limit <= cfg_data[7:0];
        end
        rmsvad_pkg::CFG_SILENCE_FRAME_LIMIT: begin
          cfg.silence_frame_limit <= cfg_data[7:0];
        end
        default: begin
        end
      endcase
    end
  end

  // energy accumulation and rms
  rmsvad_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .din         (din),
    .frame       (frame),
    .frame_ready (frame_ready)
  );

  // level meter, voice machine and result register
  rmsvad_track u_track (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .frame       (frame),
    .frame_ready (frame_ready),
    .dout        (dout)
  );

endmodule

// ----- tb/rms_energy_voice_activity_detector_unit_test.sv -----
// testbench for the rms energy voice activity detector: predicted frame results vs dout
module rms_energy_voice_activity_detector_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rmsvad_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int MAX_IDLE      = 11;
  localparam int SETTLE_CYCLES = 80;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 1500;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int PHASE_ITEMS   = 240;
  localparam int MAX_PRINTS    = 200;
  localparam int FULL_SCALE    = 32768;

  // index with no register behind it
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

  typedef struct packed {
    logic [RMS_W-1:0]   rms;
    logic [LEVEL_W-1:0] level;
    logic               speech;
    logic               wake;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  rmsvad_in_if  din_ch ();
  rmsvad_out_if dout_ch ();

  rms_energy_voice_activity_detector_unit dut (
    .clk       (clk),
    .rst       (rst),
    .din       (din_ch),
    .dout      (dout_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted detector state and register copies
  logic [SUM_W-1:0]   acc_energy;
  logic [COUNT_W-1:0] acc_count;
  logic [31:0]        level_avg;
  logic               in_speech;
  logic [RUN_W-1:0]   loud_frames;
  logic [RUN_W-1:0]   quiet_frames;
  logic               wake_seen;
  logic [15:0]        thr_reg;
  logic [7:0]         speech_lim_reg;
  logic [7:0]         silence_lim_reg;

  frame_result_t expected_frames[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  items_sent = 0;
  int  rx_hold_request = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;

  always #HALF_PERIOD clk = ~clk;

  // run length guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS) begin
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
    end
    error_count++;
  endtask

  // integer square root, one result bit per pass from the top
  function automatic logic [16:0] floor_root(input logic [SUM_W-1:0] v);
    logic [16:0] root;
    logic [16:0] trial;
    logic [33:0] square;
    root = '0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (17'd1 << b);
      square = 34'(trial) * 34'(trial);
      if (SUM_W'(square) <= v) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic void reset_predictor();
    acc_energy      = '0;
    acc_count       = '0;
    level_avg       = '0;
    in_speech       = 1'b0;
    loud_frames     = '0;
    quiet_frames    = '0;
    wake_seen       = 1'b0;
    thr_reg         = RESET_RMS_THRESHOLD;
    speech_lim_reg  = RESET_SPEECH_FRAME_LIMIT;
    silence_lim_reg = RESET_SILENCE_FRAME_LIMIT;
  endfunction

  // accumulate one accepted item; a closing sample queues the frame result
  function automatic void predict_item(input logic op, input logic signed [15:0] smp,
                                       input logic last);
    logic [16:0]      mag;
    logic [SUM_W-1:0] quo;
    logic [RMS_W-1:0] rms;
    logic [31:0]      pct;
    frame_result_t    res;
    if (op == OP_CLEAR) begin
      wake_seen = 1'b0;
      return;
    end
    mag = (smp < 0) ? 17'(-int'(smp)) : 17'(int'(smp));
    acc_energy = acc_energy + SUM_W'(mag) * SUM_W'(mag);
    acc_count++;
    if (!last && acc_count < COUNT_W'(MAX_FRAME_SAMPLES)) begin
      return;
    end
    quo = acc_energy / SUM_W'(acc_count);
    rms = RMS_W'(floor_root(quo));
    acc_energy = '0;
    acc_count = '0;
    level_avg = (level_avg * 32'(SMOOTH_MUL) + 32'(rms)) >> SMOOTH_SH;
    pct = (level_avg * 32'(PCT_MUL)) >> PCT_SH;
    if (pct > 32'(LEVEL_MAX)) begin
      pct = 32'(LEVEL_MAX);
    end
    // silence/speech machine
    if (rms >= thr_reg) begin
      if (loud_frames != RUN_W'(RUN_MAX)) begin
        loud_frames++;
      end
      quiet_frames = '0;
      if (!in_speech && loud_frames >= speech_lim_reg) begin
        in_speech = 1'b1;
        wake_seen = 1'b1;
      end
    end else begin
      if (quiet_frames != RUN_W'(RUN_MAX)) begin
        quiet_frames++;
      end
      loud_frames = '0;
      if (in_speech && quiet_frames >= silence_lim_reg) begin
        in_speech = 1'b0;
      end
    end
    res.rms    = rms;
    res.level  = LEVEL_W'(pct);
    res.speech = in_speech;
    res.wake   = wake_seen;
    expected_frames.push_back(res);
  endfunction

  // one item transfer on din, with a random lead gap while tx_idle_on is set
  task automatic send_item(input logic op, input logic signed [15:0] smp, input logic last);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    repeat (gap) begin
      @(negedge clk);
      din_ch.valid = 1'b0;
    end
    @(negedge clk);
    din_ch.valid      = 1'b1;
    din_ch.opcode     = op;
    din_ch.sample     = smp;
    din_ch.frame_last = last;
    @(posedge clk);
    while (!din_ch.ready) @(posedge clk);
    predict_item(op, smp, last);
    items_sent++;
  endtask

  function automatic logic signed [15:0] make_sample(input int m);
    if (m >= FULL_SCALE) begin
      return 16'sh8000;
    end
    return 16'(($urandom_range(0, 1) != 0) ? -m : m);
  endfunction

  // a frame of len samples near magnitude base; a negative base gives noise
  task automatic send_frame(input int len, input int base);
    int  m;
    bit  jitter;
    logic signed [15:0] smp;
    jitter = $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if (base < 0) begin
        smp = 16'($urandom);
      end else begin
        m = jitter ? base + $urandom_range(0, 8) - 4 : base;
        if (m < 0) m = 0;
        if (m > FULL_SCALE) m = FULL_SCALE;
        smp = make_sample(m);
      end
      send_item(OP_SAMPLE, smp, i == len - 1);
    end
  endtask

  function automatic int loud_level();
    int m;
    m = int'(thr_reg);
    if ($urandom_range(0, 3) != 0) m += $urandom_range(0, 400);
    return (m > FULL_SCALE) ? FULL_SCALE : m;
  endfunction

  function automatic int quiet_level();
    int t;
    int span;
    t = int'(thr_reg);
    if (t == 0) return $urandom_range(0, FULL_SCALE);
    case ($urandom_range(0, 3))
      0: begin
        return t - 1;
      end
      1: begin
        return $urandom_range(0, t - 1);
      end
      default: begin
        span = (t - 1 > 400) ? 400 : t - 1;
        return t - 1 - $urandom_range(0, span);
      end
    endcase
  endfunction

  // longest useful run of one kind under the current limits
  function automatic int run_span(input bit loud);
    int lim;
    lim = loud ? int'(speech_lim_reg) : int'(silence_lim_reg);
    return (lim + 2 > 20) ? 20 : lim + 2;
  endfunction

  // stop offering and let every queued frame come out
  task automatic settle_idle();
    @(negedge clk);
    din_ch.valid = 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_RMS_THRESHOLD: begin
        thr_reg = data;
      end
      CFG_SPEECH_FRAME_LIMIT: begin
        speech_lim_reg = data[7:0];
      end
      CFG_SILENCE_FRAME_LIMIT: begin
        silence_lim_reg = data[7:0];
      end
      default: begin
      end
    endcase
  endtask

  // junk fills the unused upper byte of the 8-bit registers
  task automatic apply_settings(input int thr, input int sp, input int si, input bit junk);
    logic [7:0] hi_sp;
    logic [7:0] hi_si;
    hi_sp = junk ? 8'($urandom) : 8'd0;
    hi_si = junk ? 8'($urandom) : 8'd0;
    settle_idle();
    write_reg(CFG_RMS_THRESHOLD, 16'(thr));
    write_reg(CFG_SPEECH_FRAME_LIMIT, {hi_sp, 8'(sp)});
    write_reg(CFG_SILENCE_FRAME_LIMIT, {hi_si, 8'(si)});
  endtask

  // mostly runs of loud or quiet frames, with noise frames, clears and a rare long loud frame mixed in
  task automatic run_traffic(input int n_items);
    int start;
    int pick;
    int runs;
    bit loud;
    start = items_sent;
    while (items_sent - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_item(OP_CLEAR, 16'($urandom), 1'($urandom));
      end else if (pick < 20) begin
        send_frame($urandom_range(1, 8), -1);
      end else if (pick < 21) begin
        send_frame($urandom_range(100, 600), loud_level());
      end else begin
        loud = $urandom_range(0, 1);
        runs = ($urandom_range(0, 3) == 0) ? $urandom_range(1, run_span(loud))
                                           : $urandom_range(1, 4);
        repeat (runs) begin
          send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4),
                     loud ? loud_level() : quiet_level());
        end
      end
    end
  endtask

  // receiver: random hold-off before each transfer while rx_idle_on is set, or a long one on request
  initial begin : result_sink
    int wait_cycles;
    dout_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (rx_hold_request > 0) begin
        wait_cycles = rx_hold_request;
        rx_hold_request = 0;
      end else begin
        wait_cycles = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      repeat (wait_cycles) begin
        @(negedge clk);
        dout_ch.ready = 1'b0;
      end
      @(negedge clk);
      dout_ch.ready = 1'b1;
      @(posedge clk);
      while (!dout_ch.valid) @(posedge clk);
    end
  end

  // compare each result transfer with the oldest predicted frame
  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (rst === 1'b0 && dout_ch.valid === 1'b1 && dout_ch.ready === 1'b1) begin
      if (expected_frames.size() == 0) begin
        report_mismatch($sformatf("result with no frame pending, rms %0d", dout_ch.frame_rms));
      end else begin
        want = expected_frames.pop_front();
        if (dout_ch.frame_rms !== want.rms)
          report_mismatch($sformatf("frame_rms %0d, want %0d", dout_ch.frame_rms, want.rms));
        if (dout_ch.level_percent !== want.level)
          report_mismatch($sformatf("level_percent %0d, want %0d",
                                    dout_ch.level_percent, want.level));
        if (dout_ch.speech_active !== want.speech)
          report_mismatch($sformatf("speech_active %0b, want %0b",
                                    dout_ch.speech_active, want.speech));
        if (dout_ch.wake_latched !== want.wake)
          report_mismatch($sformatf("wake_latched %0b, want %0b",
                                    dout_ch.wake_latched, want.wake));
      end
    end
  end

  // rail values, threshold boundary and a mixed frame under reset settings
  task automatic test_frame_extremes();
    send_item(OP_SAMPLE, 16'sh7fff, 1'b1);
    send_item(OP_SAMPLE, 16'sh8000, 1'b1);
    send_item(OP_SAMPLE, 16'sh0000, 1'b1);
    send_item(OP_SAMPLE, 16'sh0001, 1'b0);
    send_item(OP_SAMPLE, -16'sd1, 1'b1);
    send_item(OP_SAMPLE, 16'sd900, 1'b1);
    send_item(OP_SAMPLE, 16'sd899, 1'b1);
    send_item(OP_SAMPLE, 16'sh7fff, 1'b0);
    send_item(OP_SAMPLE, 16'sh8000, 1'b0);
    send_item(OP_SAMPLE, 16'sh0000, 1'b1);
  endtask

  // clear drops the latch, ignores its fields and leaves an open frame alone
  task automatic test_wake_clear();
    send_item(OP_CLEAR, 16'sh8000, 1'b1);
    send_item(OP_SAMPLE, 16'sd1000, 1'b0);
    send_item(OP_CLEAR, 16'sh7fff, 1'b0);
    send_item(OP_SAMPLE, 16'sd1000, 1'b1);
    apply_settings(RESET_RMS_THRESHOLD, RESET_SPEECH_FRAME_LIMIT, 1, 1'b0);
    send_item(OP_SAMPLE, 16'sd12, 1'b1);
    send_item(OP_SAMPLE, -16'sd2000, 1'b1);
    send_item(OP_SAMPLE, 16'sd2000, 1'b1);
    send_item(OP_CLEAR, 16'sh0000, 1'b0);
    send_item(OP_CLEAR, 16'shffff, 1'b1);
    send_item(OP_SAMPLE, 16'sd2000, 1'b1);
  endtask

  // frames that hit the sample limit, with and without frame_last
  task automatic test_full_frame();
    settle_idle();
    tx_idle_on = 1'b0;
    repeat (MAX_FRAME_SAMPLES) send_item(OP_SAMPLE, 16'sh8000, 1'b0);
    send_item(OP_SAMPLE, 16'sd5, 1'b1);
    tx_idle_on = 1'b1;
    repeat (MAX_FRAME_SAMPLES - 1) send_item(OP_SAMPLE, 16'($urandom), 1'b0);
    send_item(OP_SAMPLE, 16'($urandom), 1'b1);
  endtask

  // long runs at the top limits so both counters reach saturation
  task automatic test_run_saturation();
    apply_settings(RESET_RMS_THRESHOLD, RUN_MAX, RUN_MAX, 1'b0);
    tx_idle_on = 1'b0;
    repeat (258) send_frame(1, 100);
    repeat (290) send_frame(1, 2000);
    repeat (258) send_frame(1, 100);
    tx_idle_on = 1'b1;
  endtask

  // receiver holds off long while closing frames keep coming
  task automatic test_output_backpressure();
    settle_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    rx_hold_request = HOLD_CYCLES;
    repeat (8) send_frame($urandom_range(1, 2), ($urandom_range(0, 1) != 0) ? -1 : 3000);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // random traffic across a spread of register settings
  task automatic test_random_settings();
    apply_settings(RESET_RMS_THRESHOLD, RESET_SPEECH_FRAME_LIMIT, RESET_SILENCE_FRAME_LIMIT,
                   1'b0);
    run_traffic(PHASE_ITEMS);

    apply_settings(0, 0, 0, 1'b0);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_traffic(PHASE_ITEMS);

    apply_settings(FULL_SCALE, 1, 1, 1'b1);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_traffic(PHASE_ITEMS);

    apply_settings(1500, 0, 0, 1'b0);
    rx_idle_on = 1'b0;
    run_traffic(PHASE_ITEMS);

    apply_settings($urandom_range(200, 3000), $urandom_range(1, 6), $urandom_range(1, 6), 1'b1);
    write_reg(CFG_UNUSED_INDEX, 16'($urandom));
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    run_traffic(PHASE_ITEMS);

    apply_settings($urandom_range(0, FULL_SCALE), RUN_MAX, 1, 1'b0);
    tx_idle_on = 1'b1;
    run_traffic(PHASE_ITEMS);
  endtask

  initial begin : main_flow
    int waited;
    rst               = 1'b1;
    din_ch.valid      = 1'b0;
    din_ch.opcode     = OP_SAMPLE;
    din_ch.sample     = '0;
    din_ch.frame_last = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_RMS_THRESHOLD;
    cfg_data          = '0;
    reset_predictor();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_frame_extremes();
    test_wake_clear();
    test_full_frame();
    test_run_saturation();
    test_output_backpressure();
    test_random_settings();

    // drain, then let the tail settle before the verdict
    @(negedge clk);
    din_ch.valid = 1'b0;
    waited = 0;
    while (expected_frames.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_frames.size() != 0) begin
      report_mismatch($sformatf("%0d frame results never arrived", expected_frames.size()));
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
